// ----- hw/rtl/lahs_pkg.sv -----
package lahs_pkg;

    // Default axis geometry: pulses per motor revolution and travel per revolution.
    localparam int PULSES_PER_REV_DEF = 12;
    localparam int MM_PER_REV_DEF     = 5;

    // Fixed field and state widths.
    localparam int CNT_W  = 24;  // signed pulse count
    localparam int DIST_W = 22;  // saturated travel distance in mm
    localparam int POS_W  = 23;  // signed position in mm
    localparam int HALF_W = 21;  // half travel range in mm

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_FRONT  = 3'd1,
        ST_BACK   = 3'd2,
        ST_CENTRE = 3'd3,
        ST_DONE   = 3'd4
    } seq_state_t;

    typedef enum logic [1:0] {
        DIR_STOP  = 2'd0,
        DIR_FRONT = 2'd1,
        DIR_BACK  = 2'd2
    } motor_dir_t;

    typedef enum logic {
        MODE_MANUAL = 1'b0,
        MODE_AUTO   = 1'b1
    } op_mode_t;

    // One sampled tick of switch, pulse and button inputs.
    typedef struct packed {
        logic front_switch;
        logic back_switch;
        logic motor_pulse;
        logic start_calibration;
        logic confirm_center;
        logic mode_request_valid;
        logic mode_request;
    } sample_t;

    // Pulse tracker controls from the sequencer.
    typedef struct packed {
        logic up;
        logic down;
        logic clear;
    } trk_ctrl_t;

endpackage

// ----- hw/rtl/lahs_sample_reg.sv -----
module lahs_sample_reg
    import lahs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  logic    front_switch,
    input  logic    back_switch,
    input  logic    motor_pulse,
    input  logic    start_calibration,
    input  logic    confirm_center,
    input  logic    mode_request_valid,
    input  logic    mode_request,
    input  logic    res_take,
    output sample_t s1,
    output logic    s1_valid
);

    logic    valid_reg;
    logic    valid_next;
    sample_t data_reg;
    logic    load;

    // Slot frees up when empty or when its request moves on this cycle.
    assign load         = !valid_reg || res_take;
    assign sample_stall = !load;
    assign valid_next   = load ? sample_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && sample_valid)
        begin
            data_reg <= '{front_switch, back_switch, motor_pulse, start_calibration,
                          confirm_center, mode_request_valid, mode_request};
        end
    end

    assign s1       = data_reg;
    assign s1_valid = valid_reg;

endmodule

// ----- hw/rtl/lahs_dist_track.sv -----
module lahs_dist_track
    import lahs_pkg::*;
#(
    parameter int PULSES_PER_REV = PULSES_PER_REV_DEF,
    parameter int MM_PER_REV     = MM_PER_REV_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  trk_ctrl_t         ctrl,
    output logic [DIST_W-1:0] dist_upd
);

    // Keep floor(count*MM/PPR) exactly as quotient and remainder, stepped per pulse.
    localparam int Q     = MM_PER_REV / PULSES_PER_REV;
    localparam int R     = MM_PER_REV % PULSES_PER_REV;
    localparam int REM_W = $clog2(PULSES_PER_REV + 1);
    localparam int SUM_W = REM_W + 1;
    localparam int RAW_W = CNT_W + $clog2(MM_PER_REV + 1);

    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    logic signed [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic signed [RAW_W-1:0] raw_reg, raw_next, raw_upd;
    logic [REM_W-1:0]        rem_reg, rem_next, rem_upd;
    logic [SUM_W-1:0]        rem_sum;
    logic                    carry;
    logic                    borrow;
    logic                    do_up;
    logic                    do_down;

    assign do_up   = ctrl.up && (cnt_reg != CNT_MAX);
    assign do_down = ctrl.down && (cnt_reg != CNT_MIN);

    assign rem_sum = {1'b0, rem_reg} + SUM_W'(R);
    assign carry   = rem_sum >= SUM_W'(PULSES_PER_REV);
    assign borrow  = rem_reg < REM_W'(R);

    always_comb
    begin
        cnt_upd = cnt_reg;
        raw_upd = raw_reg;
        rem_upd = rem_reg;
        if (do_up)
        begin
            cnt_upd = cnt_reg + CNT_W'(1);
            raw_upd = raw_reg + RAW_W'(Q) + RAW_W'(carry);
            rem_upd = carry ? REM_W'(rem_sum - SUM_W'(PULSES_PER_REV)) : REM_W'(rem_sum);
        end
        else if (do_down)
        begin
            cnt_upd = cnt_reg - CNT_W'(1);
            raw_upd = raw_reg - RAW_W'(Q) - RAW_W'(borrow);
            rem_upd = borrow ? REM_W'({1'b0, rem_reg} + SUM_W'(PULSES_PER_REV - R))
                             : REM_W'({1'b0, rem_reg} - SUM_W'(R));
        end
    end

    // Clamp: negative or zero reads as zero, large values saturate.
    always_comb
    begin
        if (raw_upd[RAW_W-1])
        begin
            dist_upd = '0;
        end
        else if (|raw_upd[RAW_W-2:DIST_W])
        begin
            dist_upd = '1;
        end
        else
        begin
            dist_upd = raw_upd[DIST_W-1:0];
        end
    end

    assign cnt_next = ctrl.clear ? '0 : cnt_upd;
    assign raw_next = ctrl.clear ? '0 : raw_upd;
    assign rem_next = ctrl.clear ? '0 : rem_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            raw_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            raw_reg <= raw_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ----- hw/rtl/lahs_seq.sv -----
module lahs_seq
    import lahs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sample_t                 s,
    input  logic                    s1_valid,
    input  logic                    result_stall,
    input  logic [DIST_W-1:0]       dist_upd,
    output logic                    res_take,
    output trk_ctrl_t               trk,
    output logic                    result_valid,
    output seq_state_t              state_q,
    output motor_dir_t              dir_q,
    output logic signed [POS_W-1:0] pos_q,
    output logic [HALF_W-1:0]       half_q,
    output logic signed [POS_W-1:0] centre_q,
    output op_mode_t                mode_q,
    output logic                    homed_q
);

    seq_state_t              state_reg, state_next, step_state;
    motor_dir_t              dir_reg, dir_next;
    logic signed [POS_W-1:0] pos_reg, pos_next, pos_a, pos_b;
    logic [HALF_W-1:0]       half_reg, half_next, half_b;
    logic signed [POS_W-1:0] centre_reg, centre_next;
    op_mode_t                mode_reg, mode_next;
    logic                    homed_reg, homed_next, homed_b;
    logic                    result_valid_reg;
    logic                    adv;
    logic                    cnt_en;
    logic                    go_back, go_centre, go_done, start_ok;

    assign res_take = !result_valid_reg || !result_stall;
    assign adv      = s1_valid && res_take;

    assign cnt_en = s.motor_pulse && (state_reg == ST_BACK || state_reg == ST_CENTRE ||
                                      state_reg == ST_DONE);

    // Position after this request's pulse, before the sequence step.
    assign pos_a = (cnt_en && (state_reg == ST_CENTRE || state_reg == ST_DONE))
                 ? ($signed({1'b0, dist_upd}) - $signed({2'b00, half_reg}))
                 : pos_reg;

    assign go_back   = (state_reg == ST_FRONT) && s.front_switch;
    assign go_centre = (state_reg == ST_BACK) && s.back_switch;
    assign go_done   = (state_reg == ST_CENTRE) && (pos_a == '0);
    assign half_b    = go_centre ? dist_upd[DIST_W-1:1] : half_reg;
    assign pos_b     = go_centre ? $signed({2'b00, half_b}) : pos_a;
    assign homed_b   = homed_reg || s.confirm_center;

    // Next state
    always_comb
    begin
        case (state_reg)
            ST_FRONT:  step_state = go_back ? ST_BACK : ST_FRONT;
            ST_BACK:   step_state = go_centre ? ST_CENTRE : ST_BACK;
            ST_CENTRE: step_state = go_done ? ST_DONE : ST_CENTRE;
            ST_IDLE:   step_state = ST_IDLE;
            ST_DONE:   step_state = ST_DONE;
            default:   step_state = ST_IDLE;
        endcase
        start_ok   = s.start_calibration && (step_state == ST_IDLE || step_state == ST_DONE);
        state_next = state_reg;
        if (adv)
        begin
            state_next = start_ok ? ST_FRONT : step_state;
        end
    end

    // Outputs and datapath
    always_comb
    begin
        dir_next    = dir_reg;
        pos_next    = pos_reg;
        half_next   = half_reg;
        centre_next = centre_reg;
        homed_next  = homed_reg;
        mode_next   = mode_reg;
        trk         = '0;
        if (adv)
        begin
            if (go_back)
            begin
                dir_next = DIR_BACK;
            end
            else if (go_centre)
            begin
                dir_next = DIR_FRONT;
            end
            else if (go_done)
            begin
                dir_next = DIR_STOP;
            end
            if (start_ok)
            begin
                dir_next = DIR_FRONT;
            end
            pos_next  = pos_b;
            half_next = half_b;
            if (s.confirm_center)
            begin
                centre_next = pos_b;
            end
            homed_next = homed_b;
            if (s.mode_request_valid && (!s.mode_request || homed_b))
            begin
                mode_next = op_mode_t'(s.mode_request);
            end
            trk.up    = cnt_en && (dir_reg == DIR_BACK);
            trk.down  = cnt_en && (dir_reg == DIR_FRONT);
            trk.clear = start_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dir_reg          <= DIR_STOP;
            pos_reg          <= '0;
            half_reg         <= '0;
            centre_reg       <= '0;
            mode_reg         <= MODE_MANUAL;
            homed_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dir_reg    <= dir_next;
            pos_reg    <= pos_next;
            half_reg   <= half_next;
            centre_reg <= centre_next;
            mode_reg   <= mode_next;
            homed_reg  <= homed_next;
            if (res_take)
            begin
                result_valid_reg <= s1_valid;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign state_q      = state_reg;
    assign dir_q        = dir_reg;
    assign pos_q        = pos_reg;
    assign half_q       = half_reg;
    assign centre_q     = centre_reg;
    assign mode_q       = mode_reg;
    assign homed_q      = homed_reg;

`ifndef SYNTHESIS
    a_stop_when_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) == (dir_reg == DIR_STOP))
        else $error("motor direction disagrees with sequence state");

    a_homed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        homed_reg |=> homed_reg)
        else $error("homed flag dropped");

    a_auto_needs_homed: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_AUTO) |-> homed_reg)
        else $error("automatic mode without homing");

    a_done_from_centre: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && $past(state_reg) != ST_DONE) |->
        ($past(state_reg) == ST_CENTRE))
        else $error("done reached without centre run");
`endif

endmodule

// ----- hw/rtl/linear_axis_homing_sequencer.sv -----
// Linear axis homing sequencer.
// Sample channel: one request per tick of sampled switches, motor pulse and
// buttons (sample_valid / sample_stall). Result channel: one result per
// request with sequence state, motor command, position, half range, centre,
// mode and permission flags (result_valid / result_stall). A request is taken
// on a rising edge with valid high and stall low.
// Pipeline: a request passes two register stages (sample register, then
// state/result registers) before its result shows. Throughput: one request
// per cycle while result_stall is low; the pulse count to mm conversion is
// kept as a running quotient and remainder; each pulse costs one add step.
// When result_stall is high the result holds, the sample register keeps one
// more request, and sample_stall rises only once both stages are full.
// Reset (rst_n low, asynchronous): sequence idle, motor stopped, count,
// position, half range and centre zero, manual mode, not homed, both stages
// empty.
module linear_axis_homing_sequencer
    import lahs_pkg::*;
#(
    parameter int PULSES_PER_REV = PULSES_PER_REV_DEF,
    parameter int MM_PER_REV     = MM_PER_REV_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  logic                    front_switch,
    input  logic                    back_switch,
    input  logic                    motor_pulse,
    input  logic                    start_calibration,
    input  logic                    confirm_center,
    input  logic                    mode_request_valid,
    input  logic                    mode_request,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [2:0]              sequence_state,
    output logic [1:0]              motor_command,
    output logic signed [POS_W-1:0] position_mm,
    output logic [HALF_W-1:0]       half_range_mm,
    output logic signed [POS_W-1:0] centre_mm,
    output logic                    mode_now,
    output logic                    manual_allowed,
    output logic                    is_homed
);

    sample_t                 s1;
    logic                    s1_valid;
    logic                    res_take;
    trk_ctrl_t               trk;
    logic [DIST_W-1:0]       dist_upd;
    seq_state_t              state_q;
    motor_dir_t              dir_q;
    op_mode_t                mode_q;

    // Input stage: hold one request while the result side is stalled.
    lahs_sample_reg u_sample (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .front_switch       (front_switch),
        .back_switch        (back_switch),
        .motor_pulse        (motor_pulse),
        .start_calibration  (start_calibration),
        .confirm_center     (confirm_center),
        .mode_request_valid (mode_request_valid),
        .mode_request       (mode_request),
        .res_take           (res_take),
        .s1                 (s1),
        .s1_valid           (s1_valid)
    );

    // Pulse count and its floored mm distance, advanced one pulse at a time.
    lahs_dist_track #(
        .PULSES_PER_REV (PULSES_PER_REV),
        .MM_PER_REV     (MM_PER_REV)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (trk),
        .dist_upd (dist_upd)
    );

    // Sequence control; its state registers double as the result register.
    lahs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .s            (s1),
        .s1_valid     (s1_valid),
        .result_stall (result_stall),
        .dist_upd     (dist_upd),
        .res_take     (res_take),
        .trk          (trk),
        .result_valid (result_valid),
        .state_q      (state_q),
        .dir_q        (dir_q),
        .pos_q        (position_mm),
        .half_q       (half_range_mm),
        .centre_q     (centre_mm),
        .mode_q       (mode_q),
        .homed_q      (is_homed)
    );

    assign sequence_state = state_q;
    assign motor_command  = dir_q;
    assign mode_now       = mode_q;
    // Manual moves only while parked and in manual mode.
    assign manual_allowed = (mode_q == MODE_MANUAL) &&
                            (state_q == ST_IDLE || state_q == ST_DONE);

endmodule
